[hw/rtl/akinv_pkg.sv]
// Shared types and constants for the affine key inverter.
// Used by the serial divider, the top level and the port checker.
package akinv_pkg;

  localparam int unsigned WORD_BITS      = 16;
  localparam int unsigned DIVD_BITS      = 2 * WORD_BITS;
  localparam int unsigned T_BITS         = WORD_BITS + 2;
  localparam int unsigned MA_BITS        = WORD_BITS + 1;
  localparam int unsigned PROD_BITS      = MA_BITS + T_BITS;
  localparam int unsigned CNT_BITS       = $clog2(DIVD_BITS + 1);
  localparam int unsigned IN_TDATA_BITS  = ((3 * WORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_BITS = ((4 * WORD_BITS + 7) / 8) * 8;

  // Field offsets inside the stream words
  localparam int unsigned OFF_MULT_KEY   = 0;
  localparam int unsigned OFF_ADD_KEY    = WORD_BITS;
  localparam int unsigned OFF_MODULUS    = 2 * WORD_BITS;
  localparam int unsigned OFF_INV_MULT   = 0;
  localparam int unsigned OFF_RED_OFFSET = WORD_BITS;
  localparam int unsigned OFF_INV_OFFSET = 2 * WORD_BITS;
  localparam int unsigned OFF_DEC_OFFSET = 3 * WORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_EUC_CHK,
    ST_EUC_WAIT,
    ST_EUC_MUL,
    ST_EUC_UPD,
    ST_FIX,
    ST_PROD,
    ST_PMOD_GO,
    ST_PMOD_WAIT,
    ST_OUT
  } akinv_state_e;

  typedef struct packed {
    logic                 start;
    logic                 wide;
    logic [DIVD_BITS-1:0] dividend;
    logic [WORD_BITS-1:0] divisor;
  } akinv_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] quo;
    logic [WORD_BITS-1:0] rem;
  } akinv_div_rsp_t;

endpackage

[hw/rtl/akinv_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Narrow mode divides a WORD_BITS dividend, wide mode a 2*WORD_BITS one.
// Depends on akinv_pkg.
module akinv_div import akinv_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  akinv_div_req_t req_i,
  output akinv_div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS-1:0] dvs_q, dvs_d;
  logic [DIVD_BITS-1:0] dq_q, dq_d;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 fits;

  assign trial = {rem_q, dq_q[DIVD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dq_d   = dq_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      if (req_i.wide) begin
        dq_d  = req_i.dividend;
        cnt_d = CNT_BITS'(DIVD_BITS);
      end else begin
        // left-align the narrow dividend so its msb shifts out first
        dq_d  = {req_i.dividend[WORD_BITS-1:0], {WORD_BITS{1'b0}}};
        cnt_d = CNT_BITS'(WORD_BITS);
      end
    end else if (busy_q) begin
      rem_d = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      dq_d  = {dq_q[DIVD_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dq_q[WORD_BITS-1:0];
  assign rsp_o.rem  = rem_q;

endmodule

[hw/rtl/affine_key_inverter.sv]
// Affine key inverter top level: sequencer, Euclid registers and output stage.
// Depends on akinv_pkg and akinv_div.
//
// Usage:
//   Slave stream takes one key request: multiplier, offset and modulus in
//   tdata. Master stream returns one result: tuser is the status (1 when the
//   multiplier has no inverse modulo n, or n is zero), tdata carries the
//   inverse multiplier, reduced offset, additive inverse and decryption offset.
//   Each request runs a set-up reduction of the offset, one division per
//   Euclid iteration and a final reduction of the decryption offset; a
//   multiplier with no inverse skips the final reduction. The shared serial
//   divider (one quotient bit a cycle) does every division; a zero modulus
//   skips the divider and goes straight to the output state.
//   s_axis_tready_o is high only while the sequencer is idle; one request is
//   worked on at a time. The result sits in an output register, so a new
//   request is taken while the previous result still waits; the sequencer then
//   holds its finished result until the output register is free.
//   Reset clears the sequencer and the output valid; no result is pending.
//   A stalled receiver holds tvalid, tdata and tuser unchanged.
module affine_key_inverter import akinv_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // mult_key, add_key, modulus
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // inv_mult, reduced_offset, inv_offset, dec_offset
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  // status
  output logic                      m_axis_tuser_o
);

  akinv_state_e state_q, state_d;
  akinv_div_req_t div_req;
  akinv_div_rsp_t div_rsp;

  logic                 s_acc;
  logic                 out_load;
  logic                 m_valid_q, m_valid_d;
  logic [OUT_TDATA_BITS-1:0] m_data_q;
  logic                 m_user_q;

  logic [WORD_BITS-1:0] in_a, in_b, in_n;
  logic [WORD_BITS-1:0] a_q, b_q, n_q;
  logic [WORD_BITS-1:0] rb_q, invb_q, inva_q, dec_q;
  logic                 fail_q;
  logic [WORD_BITS-1:0] r_q, nr_q, q_q, rr_q;
  logic signed [T_BITS-1:0]    t_q, nt_q;
  logic signed [PROD_BITS-1:0] prod_q;

  logic signed [MA_BITS-1:0]   mul_a;
  logic signed [T_BITS-1:0]    mul_b;
  logic signed [T_BITS-1:0]    n_ext, t_wrap, t_red;

  assign in_a  = s_axis_tdata_i[OFF_MULT_KEY +: WORD_BITS];
  assign in_b  = s_axis_tdata_i[OFF_ADD_KEY +: WORD_BITS];
  assign in_n  = s_axis_tdata_i[OFF_MODULUS +: WORD_BITS];
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  akinv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared multiplier: q*nt during Euclid, inv_a*inv_b for the decryption offset
  assign mul_a = (state_q == ST_PROD) ? $signed({1'b0, inva_q}) : $signed({1'b0, q_q});
  assign mul_b = (state_q == ST_PROD) ? $signed({2'b00, invb_q}) : nt_q;

  // Bring the Bezout coefficient into 0..n-1
  assign n_ext  = $signed({2'b00, n_q});
  assign t_wrap = t_q[T_BITS-1] ? t_q + n_ext : t_q;
  assign t_red  = (t_wrap >= n_ext) ? t_wrap - n_ext : t_wrap;

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    div_req.start   = 1'b0;
    div_req.wide    = 1'b0;
    div_req.dividend = DIVD_BITS'(r_q);
    div_req.divisor  = nr_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = (in_n == '0) ? ST_OUT : ST_RED_GO;
        end
      end
      ST_RED_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_BITS'(b_q);
        div_req.divisor  = n_q;
        state_d          = ST_RED_WAIT;
      end
      ST_RED_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_EUC_CHK;
        end
      end
      ST_EUC_CHK: begin
        if (nr_q == '0) begin
          state_d = ST_FIX;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_EUC_WAIT;
        end
      end
      ST_EUC_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_EUC_MUL;
        end
      end
      ST_EUC_MUL:  state_d = ST_EUC_UPD;
      ST_EUC_UPD:  state_d = ST_EUC_CHK;
      ST_FIX:      state_d = (r_q == WORD_BITS'(1)) ? ST_PROD : ST_OUT;
      ST_PROD:     state_d = ST_PMOD_GO;
      ST_PMOD_GO: begin
        div_req.start    = 1'b1;
        div_req.wide     = 1'b1;
        div_req.dividend = prod_q[DIVD_BITS-1:0];
        div_req.divisor  = n_q;
        state_d          = ST_PMOD_WAIT;
      end
      ST_PMOD_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold the finished result until the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          a_q    <= in_a;
          b_q    <= in_b;
          n_q    <= in_n;
          fail_q <= (in_n == '0);
          rb_q   <= '0;
          invb_q <= '0;
          inva_q <= '0;
          dec_q  <= '0;
        end
      end
      ST_RED_WAIT: begin
        if (div_rsp.done) begin
          rb_q   <= div_rsp.rem;
          invb_q <= (div_rsp.rem == '0) ? '0 : n_q - div_rsp.rem;
          t_q    <= '0;
          nt_q   <= T_BITS'(1);
          r_q    <= n_q;
          nr_q   <= a_q;
        end
      end
      ST_EUC_WAIT: begin
        if (div_rsp.done) begin
          q_q  <= div_rsp.quo;
          rr_q <= div_rsp.rem;
        end
      end
      ST_EUC_MUL, ST_PROD: begin
        prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      end
      ST_EUC_UPD: begin
        t_q  <= nt_q;
        nt_q <= t_q - T_BITS'(prod_q);
        r_q  <= nr_q;
        nr_q <= rr_q;
      end
      ST_FIX: begin
        if (r_q == WORD_BITS'(1)) begin
          inva_q <= t_red[WORD_BITS-1:0];
        end else begin
          fail_q <= 1'b1;
        end
      end
      ST_PMOD_WAIT: begin
        if (div_rsp.done) begin
          dec_q <= div_rsp.rem;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      m_data_q <= OUT_TDATA_BITS'({dec_q, invb_q, rb_q, inva_q});
      m_user_q <= fail_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

[hw/rtl/akinv_checker.sv]
// Port-level checks for the affine key inverter, bound to the top level.
// Depends on akinv_pkg.
module akinv_checker import akinv_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  input logic                      m_axis_tuser_o
);

  // One request at a time: the slave side closes after a request
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while the previous one is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // A failed inversion reports zero inverse and zero decryption offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[OFF_INV_MULT +: WORD_BITS] == '0 &&
      m_axis_tdata_o[OFF_DEC_OFFSET +: WORD_BITS] == '0)
    else $error("failed inversion with non-zero inverse or offset");

  a_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OFF_RED_OFFSET +: WORD_BITS] == '0 |->
      m_axis_tdata_o[OFF_INV_OFFSET +: WORD_BITS] == '0 &&
      m_axis_tdata_o[OFF_DEC_OFFSET +: WORD_BITS] == '0)
    else $error("zero offset gave a non-zero inverse offset");

endmodule

bind affine_key_inverter akinv_checker u_akinv_checker (.*);
